>>> src/uje_pkg.sv
// Shared types, codes and helpers for the UTF-8 JSON string escaper.
// Used by the front decoder, the command queue and the character serializer.
`default_nettype none

package uje_pkg;

    // Body codes: what follows the optional quote and the flushed raw bytes.
    localparam logic [2:0] BODY_NONE  = 3'd0;
    localparam logic [2:0] BODY_CLOSE = 3'd1;
    localparam logic [2:0] BODY_PAIR  = 3'd2;
    localparam logic [2:0] BODY_RAW   = 3'd3;
    localparam logic [2:0] BODY_UNIT1 = 3'd4;
    localparam logic [2:0] BODY_UNIT2 = 3'd5;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    // One command: the whole output of one accepted input transaction.
    typedef struct packed {
        logic        open_q;
        logic [1:0]  flush_cnt;
        logic [7:0]  flush2;
        logic [7:0]  flush1;
        logic [7:0]  flush0;
        logic [2:0]  body;
        logic [31:0] data;
    } t_cmd;

    // Lower-case hex digit of a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h57 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/utf8_json_string_escaper_unit.sv
// Top level of the UTF-8 to ASCII JSON string escaper.
// Instantiates uje_front, uje_cmd_fifo and uje_back; depends on uje_pkg.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata = data_byte[7:0], tuser = func
//   m_axis   out        tdata = out_char[7:0], tlast = last_of_run, tuser = string_end
//
// An input transaction is taken every cycle while the two-entry command
// queue has room. The serializer emits one character per cycle while the
// receiver is ready; the sustained rate is set by the output text: zero to
// twelve characters per transaction. A command's first character goes from
// its queue entry into the output register. Reset is synchronous, active low,
// and empties the queue and the output register. Either side may stall freely.
`default_nettype none

module utf8_json_string_escaper_unit import uje_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic       s_axis_tuser,   // [0] func
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_char
    output logic            m_axis_tlast,
    output logic            m_axis_tuser    // [0] string_end
);

    logic accept;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd cmd;
    t_cmd head;

    assign s_axis_tready = ~full;
    assign accept        = s_axis_tvalid & ~full;

    uje_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_func   (s_axis_tuser),
        .i_byte   (s_axis_tdata),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    uje_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    uje_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_char  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_end   (m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> src/uje_front.sv
// Front decoder: accepts string bytes, tracks UTF-8 sequences and emits one
// command per transaction that produces characters. Depends on uje_pkg.
`default_nettype none

module uje_front import uje_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic       i_func,
    input  wire logic [7:0] i_byte,
    output logic            o_push,
    output t_cmd            o_cmd
);

    logic        r_inside, n_inside;
    logic [7:0]  r_pend [3];
    logic [7:0]  n_pend [3];
    logic [1:0]  r_pcnt, n_pcnt;
    logic [2:0]  r_elen, n_elen;
    logic [20:0] r_acc, n_acc;

    logic [20:0] acc_new;
    logic [20:0] v_off;
    logic        fresh;
    t_cmd        cmd;

    assign acc_new = {r_acc[14:0], i_byte[5:0]};
    assign v_off   = acc_new - 21'h10000;

    // Next-state and command generation for one transaction.
    always_comb begin
        n_inside = r_inside;
        n_pend   = r_pend;
        n_pcnt   = r_pcnt;
        n_elen   = r_elen;
        n_acc    = r_acc;
        fresh    = 1'b0;

        cmd.open_q    = ~r_inside;
        cmd.flush_cnt = 2'd0;
        cmd.flush0    = r_pend[0];
        cmd.flush1    = r_pend[1];
        cmd.flush2    = r_pend[2];
        cmd.body      = BODY_NONE;
        cmd.data      = 32'd0;

        if (i_accept) begin
            n_inside = 1'b1;
            if (i_func) begin
                // End of string: flush a truncated sequence, then close.
                cmd.flush_cnt = r_pcnt;
                cmd.body      = BODY_CLOSE;
                n_inside      = 1'b0;
                n_pcnt        = 2'd0;
                n_elen        = 3'd0;
                n_acc         = 21'd0;
            end else if (r_elen != 3'd0 && i_byte[7:6] == 2'b10) begin
                if ({1'b0, r_pcnt} + 3'd1 >= r_elen) begin
                    // Sequence complete: one unit or a surrogate pair.
                    if (acc_new >= 21'h10000) begin
                        cmd.body = BODY_UNIT2;
                        cmd.data = {6'b110111, v_off[9:0],
                                    16'hD800 + {5'd0, v_off[20:10]}};
                    end else begin
                        cmd.body = BODY_UNIT1;
                        cmd.data = {16'd0, acc_new[15:0]};
                    end
                    n_pcnt = 2'd0;
                    n_elen = 3'd0;
                    n_acc  = 21'd0;
                end else begin
                    if (r_pcnt != 2'd3) begin
                        n_pend[r_pcnt] = i_byte;
                    end
                    n_pcnt = r_pcnt + 2'd1;
                    n_acc  = acc_new;
                end
            end else begin
                // A broken sequence is flushed raw before the byte is handled.
                if (r_elen != 3'd0) begin
                    cmd.flush_cnt = r_pcnt;
                    n_pcnt        = 2'd0;
                    n_elen        = 3'd0;
                    n_acc         = 21'd0;
                end
                fresh = 1'b1;
            end

            if (fresh) begin
                if (i_byte == CH_QUOTE || i_byte == CH_BSL) begin
                    cmd.body = BODY_PAIR;
                    cmd.data = {24'd0, i_byte};
                end else if (i_byte == 8'h0A) begin
                    cmd.body = BODY_PAIR;
                    cmd.data = {24'd0, 8'h6E};
                end else if (i_byte == 8'h0D) begin
                    cmd.body = BODY_PAIR;
                    cmd.data = {24'd0, 8'h72};
                end else if (i_byte == 8'h09) begin
                    cmd.body = BODY_PAIR;
                    cmd.data = {24'd0, 8'h74};
                end else if (i_byte == 8'h08) begin
                    cmd.body = BODY_PAIR;
                    cmd.data = {24'd0, 8'h62};
                end else if (i_byte == 8'h0C) begin
                    cmd.body = BODY_PAIR;
                    cmd.data = {24'd0, 8'h66};
                end else if (i_byte < 8'h20) begin
                    cmd.body = BODY_UNIT1;
                    cmd.data = {24'd0, i_byte};
                end else if (i_byte < 8'h80) begin
                    cmd.body = BODY_RAW;
                    cmd.data = {24'd0, i_byte};
                end else if (i_byte[7:5] == 3'b110) begin
                    n_pend[0] = i_byte;
                    n_pcnt    = 2'd1;
                    n_elen    = 3'd2;
                    n_acc     = {16'd0, i_byte[4:0]};
                end else if (i_byte[7:4] == 4'b1110) begin
                    n_pend[0] = i_byte;
                    n_pcnt    = 2'd1;
                    n_elen    = 3'd3;
                    n_acc     = {17'd0, i_byte[3:0]};
                end else if (i_byte[7:3] == 5'b11110) begin
                    n_pend[0] = i_byte;
                    n_pcnt    = 2'd1;
                    n_elen    = 3'd4;
                    n_acc     = {18'd0, i_byte[2:0]};
                end else begin
                    cmd.body = BODY_RAW;
                    cmd.data = {24'd0, i_byte};
                end
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_push = i_accept &
                    (cmd.open_q | (cmd.flush_cnt != 2'd0) | (cmd.body != BODY_NONE));

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_pcnt   <= 2'd0;
            r_elen   <= 3'd0;
            r_acc    <= 21'd0;
        end else begin
            r_inside <= n_inside;
            r_pcnt   <= n_pcnt;
            r_elen   <= n_elen;
            r_acc    <= n_acc;
        end
    end

    // Buffered sequence bytes, valid only below the fill count.
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

`default_nettype wire

>>> src/uje_cmd_fifo.sv
// Two-entry command queue between the front decoder and the serializer.
// Depends on uje_pkg for the command type.
`default_nettype none

module uje_cmd_fifo import uje_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_cmd      o_head
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> src/uje_back.sv
// Serializer: walks the head command one character per cycle, while the output
// is not stalled, into an output register. Depends on uje_pkg.
`default_nettype none

module uje_back import uje_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_empty,
    input  wire t_cmd       i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_char,
    output logic            o_last,
    output logic            o_end
);

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       r_end;
    logic [3:0] r_idx;

    logic       load;
    logic [3:0] body_len;
    logic [3:0] total;
    logic [3:0] j;
    logic [3:0] m;
    logic [3:0] r6;
    logic [15:0] unit;
    logic [7:0] ch;
    logic       is_end;
    logic       is_last;

    assign load = ~i_empty & (~r_valid | i_ready);

    // Length of the body part.
    always_comb begin
        unique case (i_head.body)
            BODY_CLOSE: body_len = 4'd1;
            BODY_PAIR:  body_len = 4'd2;
            BODY_RAW:   body_len = 4'd1;
            BODY_UNIT1: body_len = 4'd6;
            BODY_UNIT2: body_len = 4'd12;
            default:    body_len = 4'd0;
        endcase
    end

    assign total   = {3'd0, i_head.open_q} + {2'd0, i_head.flush_cnt} + body_len;
    assign is_last = (r_idx == total - 4'd1);
    assign j       = r_idx - {3'd0, i_head.open_q};
    assign m       = j - {2'd0, i_head.flush_cnt};
    assign r6      = (m >= 4'd6) ? m - 4'd6 : m;
    assign unit    = (m >= 4'd6) ? i_head.data[31:16] : i_head.data[15:0];

    // Character at the current position of the head command.
    always_comb begin
        ch     = CH_QUOTE;
        is_end = 1'b0;
        if (i_head.open_q && r_idx == 4'd0) begin
            ch = CH_QUOTE;
        end else if (j < {2'd0, i_head.flush_cnt}) begin
            case (j[1:0])
                2'd0:    ch = i_head.flush0;
                2'd1:    ch = i_head.flush1;
                default: ch = i_head.flush2;
            endcase
        end else begin
            unique case (i_head.body)
                BODY_CLOSE: begin
                    ch     = CH_QUOTE;
                    is_end = 1'b1;
                end
                BODY_PAIR: begin
                    ch = (m == 4'd0) ? CH_BSL : i_head.data[7:0];
                end
                BODY_RAW: begin
                    ch = i_head.data[7:0];
                end
                BODY_UNIT1, BODY_UNIT2: begin
                    case (r6)
                        4'd0:    ch = CH_BSL;
                        4'd1:    ch = CH_U;
                        4'd2:    ch = hex_char(unit[15:12]);
                        4'd3:    ch = hex_char(unit[11:8]);
                        4'd4:    ch = hex_char(unit[7:4]);
                        default: ch = hex_char(unit[3:0]);
                    endcase
                end
                default: ch = CH_QUOTE;
            endcase
        end
    end

    assign o_pop = load & is_last;

    // Output register and position counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 4'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? 4'd0 : r_idx + 4'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= ch;
            r_last <= is_last;
            r_end  <= is_end;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;
    assign o_end   = r_end;

endmodule

`default_nettype wire

>>> tb/utf8_json_string_escaper_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for utf8_json_string_escaper_unit: it streams UTF-8 bytes and
// end markers in, and checks every output character against a JSON escaping predictor.
// Depends on uje_pkg for the character codes and on the unit's top level only.

module utf8_json_string_escaper_unit_tb import uje_pkg::*; ();

    // Values of tuser on the input side.
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // Control bytes that take a short escape.
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_CR  = 8'h0D;

    localparam logic [127:0] HEX_DIGITS = "0123456789abcdef";
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 20;

    // One output character with its flags.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       str_end;
    } t_json_char;

    // One directed input transaction; a nonzero want holds the expected text.
    typedef struct packed {
        logic        fn;
        logic [7:0]  b;
        logic [95:0] want;
    } t_stim_row;

    localparam int N_DIRECTED = 25;
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        '{FUNC_BYTE, 8'h41, "\"A"},            // opening quote comes first
        '{FUNC_BYTE, 8'h22, "\\\""},
        '{FUNC_BYTE, 8'h5C, "\\\\"},
        '{FUNC_BYTE, 8'h0A, "\\n"},
        '{FUNC_BYTE, 8'h0D, "\\r"},
        '{FUNC_BYTE, 8'h09, "\\t"},
        '{FUNC_BYTE, 8'h08, "\\b"},
        '{FUNC_BYTE, 8'h0C, "\\f"},
        '{FUNC_BYTE, 8'h00, "\\u0000"},
        '{FUNC_BYTE, 8'h1F, "\\u001f"},
        '{FUNC_BYTE, 8'h80, 96'd0},            // stray continuation byte
        '{FUNC_BYTE, 8'hFF, 96'd0},            // byte that cannot start anything
        '{FUNC_BYTE, 8'hC3, 96'd0},            // lead byte, no output
        '{FUNC_BYTE, 8'hA9, "\\u00e9"},
        '{FUNC_BYTE, 8'hF0, 96'd0},            // four-byte sequence
        '{FUNC_BYTE, 8'h9F, 96'd0},
        '{FUNC_BYTE, 8'h98, 96'd0},
        '{FUNC_BYTE, 8'h80, "\\ud83d\\ude00"}, // surrogate pair
        '{FUNC_BYTE, 8'hE2, 96'd0},            // broken three-byte sequence
        '{FUNC_BYTE, 8'h82, 96'd0},
        '{FUNC_BYTE, 8'h41, 96'd0},
        '{FUNC_BYTE, 8'hF0, 96'd0},            // truncated by the end marker
        '{FUNC_END,  8'h00, 96'd0},
        '{FUNC_END,  8'hFF, "\"\""},           // empty string
        '{FUNC_BYTE, 8'hE9, 96'd0}             // leaves a sequence open
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;    // [7:0] data_byte
    logic       s_axis_tuser = 1'b0;    // [0] func
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_char
    logic       m_axis_tlast;
    logic       m_axis_tuser;           // [0] string_end

    // Expected text of the transaction on offer, zero when the predictor decides.
    logic [95:0] want_chars = 96'd0;

    // Predictor state.
    logic        in_string = 1'b0;
    logic [7:0]  held [3];
    int          held_cnt = 0;
    int          seq_len = 0;
    logic [20:0] code_acc = 21'd0;

    t_json_char item_chars [$];
    t_json_char chars_due [$];

    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int mismatches = 0;
    int items_in = 0;
    int ends_in = 0;
    int chars_out = 0;
    int units_out = 0;
    int idle_cycles = 0;

    utf8_json_string_escaper_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return HEX_DIGITS[8 * (15 - nib) +: 8];
    endfunction

    function automatic void emit(input logic [7:0] ch, input logic str_end);
        item_chars.insert(item_chars.size(), t_json_char'{ch, 1'b0, str_end});
    endfunction

    // A UTF-16 code unit as \uXXXX.
    function automatic void emit_code_unit(input logic [15:0] u);
        emit(CH_BSL, 1'b0);
        emit(CH_U, 1'b0);
        emit(hex_digit(u[15:12]), 1'b0);
        emit(hex_digit(u[11:8]), 1'b0);
        emit(hex_digit(u[7:4]), 1'b0);
        emit(hex_digit(u[3:0]), 1'b0);
        units_out++;
    endfunction

    // Buffered bytes of an unfinished sequence go out raw.
    function automatic void flush_held();
        for (int k = 0; k < held_cnt && k < 3; k++) begin
            emit(held[k], 1'b0);
        end
        held_cnt = 0;
        seq_len = 0;
        code_acc = 21'd0;
    endfunction

    // A byte seen with no sequence open.
    function automatic void take_fresh(input logic [7:0] b);
        case (b)
            CH_QUOTE, CH_BSL: begin emit(CH_BSL, 1'b0); emit(b, 1'b0); end
            BYTE_LF:  begin emit(CH_BSL, 1'b0); emit("n", 1'b0); end
            BYTE_CR:  begin emit(CH_BSL, 1'b0); emit("r", 1'b0); end
            BYTE_TAB: begin emit(CH_BSL, 1'b0); emit("t", 1'b0); end
            BYTE_BS:  begin emit(CH_BSL, 1'b0); emit("b", 1'b0); end
            BYTE_FF:  begin emit(CH_BSL, 1'b0); emit("f", 1'b0); end
            default: begin
                if (b < 8'h20) begin
                    emit(CH_BSL, 1'b0);
                    emit(CH_U, 1'b0);
                    emit("0", 1'b0);
                    emit("0", 1'b0);
                    emit(hex_digit(b[7:4]), 1'b0);
                    emit(hex_digit(b[3:0]), 1'b0);
                end else if (b[7:5] == 3'b110) begin
                    code_acc = {16'd0, b[4:0]};
                    seq_len = 2;
                end else if (b[7:4] == 4'b1110) begin
                    code_acc = {17'd0, b[3:0]};
                    seq_len = 3;
                end else if (b[7:3] == 5'b11110) begin
                    code_acc = {18'd0, b[2:0]};
                    seq_len = 4;
                end else begin
                    emit(b, 1'b0);
                end
                if (seq_len != 0) begin
                    held[0] = b;
                    held_cnt = 1;
                end
            end
        endcase
    endfunction

    // Works out the characters caused by one accepted input transaction.
    function automatic void escape_item(input logic fn, input logic [7:0] b,
                                        input logic [95:0] typed);
        logic [20:0] v;
        int n;
        item_chars.delete();
        if (!in_string) begin
            emit(CH_QUOTE, 1'b0);
            in_string = 1'b1;
        end
        if (fn == FUNC_END) begin
            flush_held();
            emit(CH_QUOTE, 1'b1);
            in_string = 1'b0;
        end else if (seq_len != 0 && b[7:6] == 2'b10) begin
            code_acc = {code_acc[14:0], b[5:0]};
            if (held_cnt + 1 >= seq_len) begin
                if (code_acc >= 21'h10000) begin
                    v = code_acc - 21'h10000;
                    emit_code_unit(16'hD800 + {5'd0, v[20:10]});
                    emit_code_unit(16'hDC00 + {6'd0, v[9:0]});
                end else begin
                    emit_code_unit(code_acc[15:0]);
                end
                held_cnt = 0;
                seq_len = 0;
                code_acc = 21'd0;
            end else begin
                if (held_cnt < 3) held[held_cnt] = b;
                held_cnt = held_cnt + 1;
            end
        end else begin
            flush_held();
            take_fresh(b);
        end

        // A directed row with its text typed in overrides the predicted text.
        if (typed != 96'd0) begin
            item_chars.delete();
            n = 0;
            for (int k = 0; k < 12; k++) begin
                if (typed[8 * k +: 8] != 8'd0) n = k + 1;
            end
            for (int k = 0; k < n; k++) begin
                emit(typed[8 * (n - 1 - k) +: 8], (fn == FUNC_END) && (k == n - 1));
            end
        end
        if (item_chars.size() != 0) item_chars[item_chars.size() - 1].last = 1'b1;
        foreach (item_chars[k]) chars_due.insert(chars_due.size(), item_chars[k]);
    endfunction

    task automatic report_char(input string what, input t_json_char want,
                               input t_json_char got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected char %h last %b end %b, got char %h last %b end %b",
                     $time, what, want.ch, want.last, want.str_end,
                     got.ch, got.last, got.str_end);
        end
    endtask

    // Input and output transactions are both sampled here at the clock edge.
    always @(posedge i_clk) begin
        t_json_char got;
        t_json_char want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                escape_item(s_axis_tuser, s_axis_tdata, want_chars);
                items_in++;
                if (s_axis_tuser == FUNC_END) ends_in++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
                chars_out++;
                if (chars_due.size() == 0) begin
                    report_char("output with nothing expected", '0, got);
                end else begin
                    want = chars_due.pop_front();
                    if (got.ch !== want.ch || got.last !== want.last ||
                        got.str_end !== want.str_end) begin
                        report_char("output mismatch", want, got);
                    end
                end
            end
        end
    end

    // Receiver stalls at random.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles, %0d characters outstanding",
                         IDLE_LIMIT, chars_due.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Offers one input transaction after a random gap and waits for it to be taken.
    task automatic send_item(input logic fn, input logic [7:0] b, input logic [95:0] want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= b;
        want_chars    <= want;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Holds the input idle until every expected character has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (chars_due.size() != 0);
    endtask

    // Random text: mostly well-formed UTF-8 with random content, plus stray bytes,
    // cut-off sequences and end markers.
    task automatic send_text(input int count);
        int sent;
        int kind;
        int len;
        logic [7:0] r;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(99);
            r = 8'($urandom);
            len = 0;
            if (kind < 30) begin
                send_item(FUNC_BYTE, {1'b0, r[6:0]}, 96'd0);
                sent++;
            end else if (kind < 70 || kind >= 90) begin
                if (kind < 45) begin
                    len = 2;
                    r[7:5] = 3'b110;
                end else if (kind < 58) begin
                    len = 3;
                    r[7:4] = 4'b1110;
                end else begin
                    len = 4;
                    r[7:3] = 5'b11110;
                end
                send_item(FUNC_BYTE, r, 96'd0);
                sent++;
                // A cut-off sequence stops at least one continuation byte short of its end.
                if (kind >= 90) len = $urandom_range(len - 1, 1);
                for (int k = 1; k < len; k++) begin
                    r = 8'($urandom);
                    send_item(FUNC_BYTE, {2'b10, r[5:0]}, 96'd0);
                    sent++;
                end
            end else if (kind < 80) begin
                send_item(FUNC_END, r, 96'd0);
                sent++;
            end else begin
                send_item(FUNC_BYTE, r, 96'd0);
                sent++;
            end
        end
    endtask

    initial begin
        src_idle_pct = 20;
        dst_idle_pct = 52;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_item(DIRECTED[i].fn, DIRECTED[i].b, DIRECTED[i].want);
        end
        send_text(52);
        wait_drained();

        src_idle_pct = 52;
        dst_idle_pct = 20;
        send_text(52);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        send_text(52);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (chars_due.size() != 0) begin
            $display("%0d expected characters never came out", chars_due.size());
            mismatches += chars_due.size();
        end
        $display("Streamed %0d input transactions closing %0d strings, checked %0d characters",
                 items_in, ends_in, chars_out);
        $display("including %0d decoded \\u units, under three stall patterns", units_out);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
src/uje_pkg.sv
src/uje_front.sv
src/uje_cmd_fifo.sv
src/uje_back.sv
src/utf8_json_string_escaper_unit.sv
tb/utf8_json_string_escaper_unit_tb.sv
